// ===== hw/rtl/zrps_pkg.sv =====
// ----------------------------------------------------------------------------
// zrps_pkg
// Shared types and constants for the zone range preference search block.
// ----------------------------------------------------------------------------
package zrps_pkg;

   localparam int ADDR_W    = 32;
   localparam int SHIFT_W   = 5;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd20;

   typedef enum logic {
      OP_RESTART = 1'b0,
      OP_NEXT    = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      LVL_USED_PREF = 3'd0,
      LVL_FREE_PREF = 3'd1,
      LVL_USED_KEEP = 3'd2,
      LVL_FREE_KEEP = 3'd3,
      LVL_USED      = 3'd4,
      LVL_FREE      = 3'd5,
      LVL_ALL       = 3'd6
   } level_type;

   typedef enum logic {
      REG_ZONE_SHIFT = 1'b0,
      REG_NONE       = 1'b1
   } reg_index_type;

endpackage

// ===== hw/rtl/zrps_ladder.sv =====
// ----------------------------------------------------------------------------
// zrps_ladder
// Widen a zone set by the first preference step adding a new zone, else to all.
// ----------------------------------------------------------------------------
module zrps_ladder
   import zrps_pkg::*;
#(
   parameter int ZONE_COUNT = 32
) (
   input  logic [ZONE_COUNT-1:0] base_set,
   input  logic [ZONE_COUNT-1:0] used_set,
   input  logic [ZONE_COUNT-1:0] pref_set,
   input  logic [ZONE_COUNT-1:0] disd_set,
   input  logic [ZONE_COUNT-1:0] free_set,
   output logic [ZONE_COUNT-1:0] wide_set,
   output level_type             wide_level
);

   logic [ZONE_COUNT-1:0] cand_used_pref;
   logic [ZONE_COUNT-1:0] cand_free_pref;
   logic [ZONE_COUNT-1:0] cand_used_keep;
   logic [ZONE_COUNT-1:0] cand_free_keep;

   assign cand_used_pref = used_set & pref_set;
   assign cand_free_pref = free_set & pref_set;
   assign cand_used_keep = used_set & ~disd_set;
   assign cand_free_keep = free_set & ~disd_set;

   always_comb begin
      priority if (|(cand_used_pref & ~base_set)) begin
         wide_set   = base_set | cand_used_pref;
         wide_level = LVL_USED_PREF;
      end else if (|(cand_free_pref & ~base_set)) begin
         wide_set   = base_set | cand_free_pref;
         wide_level = LVL_FREE_PREF;
      end else if (|(cand_used_keep & ~base_set)) begin
         wide_set   = base_set | cand_used_keep;
         wide_level = LVL_USED_KEEP;
      end else if (|(cand_free_keep & ~base_set)) begin
         wide_set   = base_set | cand_free_keep;
         wide_level = LVL_FREE_KEEP;
      end else if (|(used_set & ~base_set)) begin
         wide_set   = base_set | used_set;
         wide_level = LVL_USED;
      end else if (|(free_set & ~base_set)) begin
         wide_set   = base_set | free_set;
         wide_level = LVL_FREE;
      end else begin
         wide_set   = '1;
         wide_level = LVL_ALL;
      end
   end

endmodule

// ===== hw/rtl/zrps_scan.sv =====
// ----------------------------------------------------------------------------
// zrps_scan
// Find the first set zone at or after a start index and the end of its run.
// ----------------------------------------------------------------------------
module zrps_scan
   import zrps_pkg::*;
#(
   parameter int ZONE_COUNT = 32,
   parameter int IW         = $clog2(ZONE_COUNT + 1)
) (
   input  logic [ZONE_COUNT-1:0] zone_set,
   input  logic [IW-1:0]         start_index,
   output logic [IW-1:0]         run_first,
   output logic [IW-1:0]         run_end
);

   logic [ZONE_COUNT-1:0] set_hit;
   logic [ZONE_COUNT-1:0] set_iso;
   logic [ZONE_COUNT-1:0] clr_hit;
   logic [ZONE_COUNT-1:0] clr_iso;

   always_comb begin
      for (int z = 0; z < ZONE_COUNT; z++) begin
         set_hit[z] = zone_set[z] & (IW'(z) >= start_index);
      end
      set_iso   = set_hit & (~set_hit + 1'b1);
      run_first = '0;
      for (int z = 0; z < ZONE_COUNT; z++) begin
         run_first = run_first | (set_iso[z] ? IW'(z) : '0);
      end
   end

   always_comb begin
      for (int z = 0; z < ZONE_COUNT; z++) begin
         clr_hit[z] = ~zone_set[z] & (IW'(z) >= run_first);
      end
      clr_iso = clr_hit & (~clr_hit + 1'b1);
      run_end = '0;
      for (int z = 0; z < ZONE_COUNT; z++) begin
         run_end = run_end | (clr_iso[z] ? IW'(z) : '0);
      end
      if (clr_hit == '0) begin
         run_end = IW'(ZONE_COUNT);
      end
   end

endmodule

// ===== hw/rtl/zone_range_preference_search_top.sv =====
// ----------------------------------------------------------------------------
// zone_range_preference_search_top
// Path: a request word passes through the input word register, then the ladder
//   and run scan into the result register, which drives rsp_valid.
// Throughput: one word per cycle unless rsp_ready stalls; the search state
//   updates as a word leaves the input register; next word sees it at once.
// Reset: synchronous; clears both valid bits and the search state, and sets
//   zone_shift to 20.
// ----------------------------------------------------------------------------
module zone_range_preference_search_top
   import zrps_pkg::*;
#(
   parameter int ZONE_COUNT = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [31:0]         req_used_zones,
   input  logic [31:0]         req_preferred_zones,
   input  logic [31:0]         req_disdained_zones,
   input  logic [31:0]         req_free_zones,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ADDR_W-1:0]   rsp_base_address,
   output logic [ADDR_W-1:0]   rsp_limit_address,
   output logic [2:0]          rsp_ladder_level,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam int IW = $clog2(ZONE_COUNT + 1);
   localparam int CW = (ZONE_COUNT < 32) ? ZONE_COUNT : 32;

   // configuration
   logic [SHIFT_W-1:0] zone_shift_ff, zone_shift_in;
   logic               csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite
                     & (reg_index_type'(csr_paddr[2]) == REG_ZONE_SHIFT);
   assign zone_shift_in = csr_write ? csr_pwdata[SHIFT_W-1:0] : zone_shift_ff;
   assign csr_prdata = (reg_index_type'(csr_paddr[2]) == REG_ZONE_SHIFT)
                     ? CSR_DW'(zone_shift_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_shift_ff <= SHIFT_RESET;
      end else begin
         zone_shift_ff <= zone_shift_in;
      end
   end

   // input word register
   logic                  in_valid_ff, in_valid_in;
   op_type                in_op_ff;
   logic [ZONE_COUNT-1:0] in_used_ff, in_pref_ff, in_disd_ff, in_free_ff;
   logic [ZONE_COUNT-1:0] used_set, pref_set, disd_set, free_set;
   logic                  out_valid_ff, out_valid_in;
   logic                  advance;
   logic                  req_take;

   assign advance     = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready   = ~in_valid_ff | ~out_valid_ff | rsp_ready;
   assign req_take    = req_valid & req_ready;
   assign in_valid_in = req_take | (in_valid_ff & ~advance);

   always_comb begin
      used_set = '0;
      pref_set = '0;
      disd_set = '0;
      free_set = '0;
      used_set[CW-1:0] = req_used_zones[CW-1:0];
      pref_set[CW-1:0] = req_preferred_zones[CW-1:0];
      disd_set[CW-1:0] = req_disdained_zones[CW-1:0];
      free_set[CW-1:0] = req_free_zones[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= op_type'(req_operation);
         in_used_ff <= used_set;
         in_pref_ff <= pref_set;
         in_disd_ff <= disd_set;
         in_free_ff <= free_set;
      end
   end

   // search state and step logic
   logic [ZONE_COUNT-1:0] set_ff, set_in;
   logic [IW-1:0]         idx_ff, idx_in;
   level_type             level_ff, level_in;
   logic [ZONE_COUNT-1:0] from_idx;
   logic                  restart, hit, exhausted, need_widen;
   logic [ZONE_COUNT-1:0] base_set, wide_set, scan_set;
   level_type             wide_level, step_level;
   logic [IW-1:0]         scan_start, run_first, run_end;

   always_comb begin
      for (int z = 0; z < ZONE_COUNT; z++) begin
         from_idx[z] = (IW'(z) >= idx_ff);
      end
   end

   assign restart    = (in_op_ff == OP_RESTART);
   assign hit        = |(set_ff & from_idx);
   assign exhausted  = ~restart & ~hit & (set_ff == '1);
   assign need_widen = restart | ~hit;
   assign base_set   = restart ? '0 : set_ff;

   zrps_ladder #(
      .ZONE_COUNT (ZONE_COUNT)
   ) u_ladder (
      .base_set   (base_set),
      .used_set   (in_used_ff),
      .pref_set   (in_pref_ff),
      .disd_set   (in_disd_ff),
      .free_set   (in_free_ff),
      .wide_set   (wide_set),
      .wide_level (wide_level)
   );

   assign scan_set   = need_widen ? wide_set : set_ff;
   assign scan_start = need_widen ? '0 : idx_ff;
   assign step_level = need_widen ? wide_level : level_ff;

   zrps_scan #(
      .ZONE_COUNT (ZONE_COUNT),
      .IW         (IW)
   ) u_scan (
      .zone_set    (scan_set),
      .start_index (scan_start),
      .run_first   (run_first),
      .run_end     (run_end)
   );

   always_comb begin
      set_in   = set_ff;
      idx_in   = idx_ff;
      level_in = level_ff;
      if (advance) begin
         if (exhausted) begin
            level_in = LVL_ALL;
         end else begin
            set_in   = scan_set;
            idx_in   = run_end;
            level_in = step_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff   <= '0;
         idx_ff   <= '0;
         level_ff <= LVL_USED_PREF;
      end else begin
         set_ff   <= set_in;
         idx_ff   <= idx_in;
         level_ff <= level_in;
      end
   end

   // result register
   logic [ADDR_W-1:0] base_addr, limit_addr;
   logic [ADDR_W-1:0] base_ff, limit_ff;
   level_type         out_level_ff;

   assign base_addr  = ADDR_W'(run_first) << zone_shift_ff;
   assign limit_addr = (run_end == IW'(ZONE_COUNT)) ? '0
                     : (ADDR_W'(run_end) << zone_shift_ff);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (exhausted) begin
            base_ff      <= '0;
            limit_ff     <= '0;
            out_level_ff <= LVL_ALL;
         end else begin
            base_ff      <= base_addr;
            limit_ff     <= limit_addr;
            out_level_ff <= step_level;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_base_address  = base_ff;
   assign rsp_limit_address = limit_ff;
   assign rsp_ladder_level  = out_level_ff;

endmodule

// ===== hw/rtl/zrps_checker.sv =====
// ----------------------------------------------------------------------------
// zrps_checker
// Port-level checks for the zone range preference search block.
// ----------------------------------------------------------------------------
module zrps_checker
   import zrps_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [ADDR_W-1:0]   rsp_base_address,
   input logic [ADDR_W-1:0]   rsp_limit_address,
   input logic [2:0]          rsp_ladder_level,
   input logic                csr_psel,
   input logic                csr_penable,
   input logic                csr_pwrite,
   input logic [CSR_AW-1:0]   csr_paddr,
   input logic [CSR_DW-1:0]   csr_pwdata,
   input logic [CSR_DW-1:0]   csr_prdata,
   input logic                csr_pready
);

   logic zs_write;

   assign zs_write = csr_psel & csr_penable & csr_pwrite
                   & (reg_index_type'(csr_paddr[2]) == REG_ZONE_SHIFT);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_base_address)
         && $stable(rsp_limit_address) && $stable(rsp_ladder_level))
      else $error("stalled result word changed");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ladder_level <= LVL_ALL)
      else $error("ladder level beyond all zones");

   a_shift_readback: assert property (@(posedge clock) disable iff (reset)
      $past(zs_write && !reset) && (reg_index_type'(csr_paddr[2]) == REG_ZONE_SHIFT)
         |-> csr_prdata[SHIFT_W-1:0] == $past(csr_pwdata[SHIFT_W-1:0]))
      else $error("zone shift readback mismatch");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("register port stalled");

endmodule

bind zone_range_preference_search_top zrps_checker u_zrps_checker (.*);
